[design/tscbr_pkg.sv]
// ----------------------------------------------------------------------------
// tscbr_pkg
// Shared widths and types for the two-stage comb baseline removal block.
// ----------------------------------------------------------------------------
package tscbr_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int CHANNEL_W = 1;
  localparam int FILT_W    = 25;
  localparam int Y1_W      = 30;
  localparam int Y2_W      = 35;
  localparam int CH_SLOTS  = 2 ** CHANNEL_W;

  typedef enum logic {
    FE_IDLE,
    FE_CALC
  } fe_state_t;

endpackage

[design/tscbr_ram.sv]
// ----------------------------------------------------------------------------
// tscbr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tscbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[design/two_stage_comb_baseline_removal.sv]
// ----------------------------------------------------------------------------
// two_stage_comb_baseline_removal
// Per-channel two-stage integer comb high-pass that strips baseline wander.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall, beat = {sample, channel}. Each beat
// updates the history of its channel and yields exactly one filtered beat.
// Output channel: out_valid / out_stall, beat = filtered.
// The front end reads both history RAMs (two read ports each) on the
// accept edge, then computes y1 and y2 and writes back in FE_CALC, which
// holds while the output is stalled; in_stall is high in FE_CALC, so the
// next beat waits for the write-back. Scaling is a reciprocal multiply.
// Output stall freezes the whole back-end pipeline and the front end
// holds its item until the pipeline moves again; nothing is dropped.
// Reset clears the write pointers, fill flags, recent y2 values and all
// valid bits. History RAMs are not swept: entries not yet written since
// reset read as zero through per-channel fill tracking, so the block
// accepts beats right after reset.
// ----------------------------------------------------------------------------
module two_stage_comb_baseline_removal
  import tscbr_pkg::*;
#(
  parameter int CHANNELS      = 2,
  parameter int HISTORY_DEPTH = 128,
  parameter int COMB_LAG      = 80
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [CHANNEL_W-1:0]       channel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [FILT_W-1:0]   filtered
);

  localparam int IW        = $clog2(HISTORY_DEPTH);
  localparam int MEM_CH    = (CHANNELS < CH_SLOTS) ? CHANNELS : CH_SLOTS;
  localparam int MEM_DEPTH = MEM_CH * HISTORY_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  localparam int HALF_LAG = COMB_LAG / 2;
  localparam int DC_GAIN  = HALF_LAG * HALF_LAG;
  localparam int GW       = $clog2(DC_GAIN + 1);
  localparam int PRODW    = SAMPLE_W + GW;
  localparam int NUMW     = ((PRODW > Y2_W) ? PRODW : Y2_W) + 1;
  localparam int MAGW     = NUMW;
  localparam int SH       = MAGW;
  localparam int SPL      = 18;
  localparam int MHW      = MAGW - SPL;
  localparam int RHW      = SH - SPL;
  localparam int SUMW     = MAGW + SH;

  localparam longint unsigned RECIP_L = (64'd1 << SH) / DC_GAIN;
  localparam logic [SH-1:0]   RECIP    = SH'(RECIP_L);
  localparam logic [SPL-1:0]  RECIP_LO = RECIP[SPL-1:0];
  localparam logic [RHW-1:0]  RECIP_HI = RECIP[SH-1:SPL];

  localparam logic [GW-1:0]           GAIN_U   = GW'(DC_GAIN);
  localparam logic [MAGW-1:0]         GAIN_M   = MAGW'(DC_GAIN);
  localparam logic signed [PRODW-1:0] GAIN_EXT = PRODW'(DC_GAIN);

  localparam logic [IW-1:0] OFF_L   = IW'(COMB_LAG % HISTORY_DEPTH);
  localparam logic [IW-1:0] OFF_D   = IW'((COMB_LAG - 2) % HISTORY_DEPTH);
  localparam logic [IW-1:0] OFF_2   = IW'(2 % HISTORY_DEPTH);
  localparam logic          ALIAS_L = (OFF_L == '0);
  localparam logic          ALIAS_D = (OFF_D == '0);

  function automatic logic [IW-1:0] back_idx(input logic [IW-1:0] p,
                                             input logic [IW-1:0] offm);
    logic [IW:0] d;
    d = {1'b0, p} - {1'b0, offm};
    if (d[IW]) begin
      back_idx = IW'(d + (IW+1)'(HISTORY_DEPTH));
    end else begin
      back_idx = d[IW-1:0];
    end
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic ch, input logic [IW-1:0] idx);
    mem_addr = ch ? AW'(AW'(HISTORY_DEPTH) + AW'(idx)) : AW'(idx);
  endfunction

  // front-end control
  fe_state_t state, state_next;
  logic      move;
  logic      calc_done;

  logic [IW-1:0]          wp [CH_SLOTS];
  logic                   full [CH_SLOTS];
  logic signed [Y2_W-1:0] y2_prev1 [CH_SLOTS];
  logic signed [Y2_W-1:0] y2_prev2 [CH_SLOTS];

  logic                       ch_ok;
  logic [IW-1:0]              pos_in;
  logic                       full_in;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [CHANNEL_W-1:0]       ch_r;
  logic                       ok_r;
  logic [IW-1:0]              pos_r;
  logic                       vld_l_r;
  logic                       vld_d_r;
  logic                       vld_2_r;

  logic                       rd_ch;
  logic [IW-1:0]              rd_pos;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              s_addr_a, s_addr_b, f_addr_a, f_addr_b;
  logic [SAMPLE_W-1:0]        s_rd_a, s_rd_b;
  logic [Y1_W-1:0]            f_rd_a, f_rd_b;
  logic                       mem_we;

  logic signed [SAMPLE_W-1:0] xl, xd;
  logic signed [Y1_W-1:0]     y1p2, y1, y1l;
  logic signed [Y2_W-1:0]     y2;
  logic [IW-1:0]              pos_inc;
  logic                       pos_wrap;

  // back-end pipeline
  logic v1, v2, v3, v4, v5, v6;
  logic signed [Y2_W-1:0]     y2_s1, y2_s2;
  logic signed [SAMPLE_W-1:0] xd_s1;
  logic signed [PRODW-1:0]    xd_ext;
  logic signed [PRODW-1:0]    prod_s2;
  logic signed [NUMW-1:0]     num;
  logic                       sgn_s3, sgn_s4, sgn_s5, sgn_s6;
  logic [MAGW-1:0]            mag_s3, mag_s4, mag_s5, mag_s6;
  logic [2*SPL-1:0]           pp_ll;
  logic [SPL+RHW-1:0]         pp_lh;
  logic [MHW+SPL-1:0]         pp_hl;
  logic [MHW+RHW-1:0]         pp_hh;
  logic [SUMW-1:0]            pp_sum;
  logic [MAGW-1:0]            qe_s5, qe_s6;
  logic [MAGW+GW-1:0]         qg_full;
  logic [MAGW-1:0]            qg_s6;
  logic [MAGW-1:0]            rem;
  logic [MAGW-1:0]            quo;
  logic [MAGW-1:0]            res;

  assign move    = !out_valid || !out_stall;
  assign ch_ok   = int'(channel) < CHANNELS;
  assign pos_in  = wp[channel];
  assign full_in = full[channel];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FE_IDLE: begin
        if (in_valid) begin
          state_next = FE_CALC;
        end
      end
      FE_CALC: begin
        if (move) begin
          state_next = FE_IDLE;
        end
      end
      default: state_next = FE_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b0;
    calc_done = 1'b0;
    case (state)
      FE_IDLE: begin
        in_stall = 1'b0;
      end
      FE_CALC: begin
        in_stall  = 1'b1;
        calc_done = move;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // RAM read addresses: from the input beat on the accept edge, then held
  assign rd_ch    = (state == FE_IDLE) ? (channel[0] & ch_ok) : (ch_r[0] & ok_r);
  assign rd_pos   = (state == FE_IDLE) ? pos_in : pos_r;
  assign s_addr_a = mem_addr(rd_ch, back_idx(rd_pos, OFF_L));
  assign s_addr_b = mem_addr(rd_ch, back_idx(rd_pos, OFF_D));
  assign f_addr_a = mem_addr(rd_ch, back_idx(rd_pos, OFF_2));
  assign f_addr_b = mem_addr(rd_ch, back_idx(rd_pos, OFF_L));
  assign wr_addr  = mem_addr(ch_r[0] & ok_r, pos_r);
  assign mem_we   = calc_done && ok_r;

  tscbr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_sample_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (wr_addr),
    .wdata   (x_r),
    .raddr_a (s_addr_a),
    .raddr_b (s_addr_b),
    .rdata_a (s_rd_a),
    .rdata_b (s_rd_b)
  );

  tscbr_ram #(
    .WIDTH (Y1_W),
    .DEPTH (MEM_DEPTH)
  ) u_first_sum_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (wr_addr),
    .wdata   (y1),
    .raddr_a (f_addr_a),
    .raddr_b (f_addr_b),
    .rdata_a (f_rd_a),
    .rdata_b (f_rd_b)
  );

  // accept: latch the beat and which history taps are already filled
  always_ff @(posedge clk) begin
    if (state == FE_IDLE && in_valid) begin
      x_r     <= sample;
      ch_r    <= channel;
      ok_r    <= ch_ok;
      pos_r   <= pos_in;
      vld_l_r <= full_in || (pos_in >= OFF_L);
      vld_d_r <= full_in || (pos_in >= OFF_D);
      vld_2_r <= full_in || (pos_in >= OFF_2);
    end
  end

  // comb sums; taps at lag equal to the depth see the current beat
  always_comb begin
    xl   = ALIAS_L ? x_r : (vld_l_r ? signed'(s_rd_a) : '0);
    xd   = ALIAS_D ? x_r : (vld_d_r ? signed'(s_rd_b) : '0);
    y1p2 = vld_2_r ? signed'(f_rd_a) : '0;
    y1   = Y1_W'(x_r) - Y1_W'(xl) + y1p2;
    y1l  = ALIAS_L ? y1 : (vld_l_r ? signed'(f_rd_b) : '0);
    y2   = Y2_W'(y1) - Y2_W'(y1l) + y2_prev2[ch_r];
  end

  assign pos_wrap = (pos_r == IW'(HISTORY_DEPTH - 1));
  assign pos_inc  = pos_wrap ? '0 : IW'(pos_r + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CH_SLOTS; i++) begin
        wp[i]       <= '0;
        full[i]     <= 1'b0;
        y2_prev1[i] <= '0;
        y2_prev2[i] <= '0;
      end
    end else if (mem_we) begin
      wp[ch_r]       <= pos_inc;
      full[ch_r]     <= full[ch_r] || pos_wrap;
      y2_prev2[ch_r] <= y2_prev1[ch_r];
      y2_prev1[ch_r] <= y2;
    end
  end

  // scaling pipeline: trunc((xd*G - y2) / G) via reciprocal multiply
  assign xd_ext  = PRODW'(xd_s1);
  assign num     = NUMW'(prod_s2) - NUMW'(y2_s2);
  assign pp_sum  = SUMW'(pp_ll) + (SUMW'(pp_lh) << SPL) + (SUMW'(pp_hl) << SPL)
                 + (SUMW'(pp_hh) << (2 * SPL));
  assign qg_full = qe_s5 * GAIN_U;
  assign rem     = mag_s6 - qg_s6;
  assign quo     = qe_s6 + MAGW'(rem >= GAIN_M);
  assign res     = sgn_s6 ? MAGW'(-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (move) begin
      v1        <= calc_done;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      y2_s1    <= ok_r ? y2 : '0;
      xd_s1    <= ok_r ? xd : '0;
      prod_s2  <= xd_ext * GAIN_EXT;
      y2_s2    <= y2_s1;
      sgn_s3   <= num[NUMW-1];
      mag_s3   <= num[NUMW-1] ? MAGW'(-num) : MAGW'(num);
      pp_ll    <= mag_s3[SPL-1:0] * RECIP_LO;
      pp_lh    <= mag_s3[SPL-1:0] * RECIP_HI;
      pp_hl    <= mag_s3[MAGW-1:SPL] * RECIP_LO;
      pp_hh    <= mag_s3[MAGW-1:SPL] * RECIP_HI;
      sgn_s4   <= sgn_s3;
      mag_s4   <= mag_s3;
      qe_s5    <= pp_sum[SUMW-1:SH];
      sgn_s5   <= sgn_s4;
      mag_s5   <= mag_s4;
      qg_s6    <= qg_full[MAGW-1:0];
      qe_s6    <= qe_s5;
      sgn_s6   <= sgn_s5;
      mag_s6   <= mag_s5;
      filtered <= res[FILT_W-1:0];
    end
  end

endmodule

[design/tscbr_checker.sv]
// ----------------------------------------------------------------------------
// tscbr_checker
// Port-level checks for the comb baseline removal block, bound to the top.
// ----------------------------------------------------------------------------
module tscbr_checker
  import tscbr_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [SAMPLE_W-1:0] sample,
  input logic [CHANNEL_W-1:0]       channel,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [FILT_W-1:0]   filtered
);

  // the cycle after an accept is always stalled, so no two beats are accepted back to back
  a_accept_spacing: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered))
    else $error("stalled output beat changed or dropped");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind two_stage_comb_baseline_removal tscbr_checker u_tscbr_checker (.*);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-stage comb baseline removal filter.
// A directed table of extreme and patterned samples on both channels runs
// first, then about 480 random beats made of steps, ramps, full-range noise,
// rail-to-rail toggles and small wobble. Every accepted input beat is pushed
// through a local model of both comb stages and the scaled output. Filtered
// beats are compared in order. Sender and receiver idle at random in the
// first two of three phases; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top
  import tscbr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NCH          = 2;
  localparam int     HIST_DEPTH   = 128;
  localparam int     LAG          = 80;
  localparam int     OUT_DLY      = LAG - 2;
  localparam longint GAIN         = longint'(LAG / 2) * longint'(LAG / 2);
  localparam int     DIR_N        = 20;
  localparam int     PHASE_BEATS  = 160;
  localparam int     HOLD_AT      = DIR_N + 2 * PHASE_BEATS + 40;
  localparam int     HOLD_CYCLES  = 200;
  localparam int     DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic [CHANNEL_W-1:0]       ch;
    logic                       known;
    logic signed [FILT_W-1:0]   want;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic [CHANNEL_W-1:0]       channel;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [FILT_W-1:0]   filtered;

  logic signed [SAMPLE_W-1:0] smp_mem [CH_SLOTS][HIST_DEPTH];
  logic signed [Y1_W-1:0]     y1_mem  [CH_SLOTS][HIST_DEPTH];
  logic signed [Y2_W-1:0]     y2_prev [CH_SLOTS][2];
  int unsigned                wr_ptr  [CH_SLOTS];

  logic signed [FILT_W-1:0] filt_exp_q [$];
  dir_row_t                 dir_rows [DIR_N];
  int                       mismatches   = 0;
  int                       beats_sent   = 0;
  int                       send_idle_pct = 0;
  int                       recv_idle_pct = 0;
  logic                     hold_active   = 1'b0;

  two_stage_comb_baseline_removal #(
    .CHANNELS      (NCH),
    .HISTORY_DEPTH (HIST_DEPTH),
    .COMB_LAG      (LAG)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .channel   (channel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned back(input int unsigned pos, input int unsigned off);
    return (pos + HIST_DEPTH - (off % HIST_DEPTH)) % HIST_DEPTH;
  endfunction

  function automatic logic signed [FILT_W-1:0] predict_filtered(
      input logic signed [SAMPLE_W-1:0] x, input logic [CHANNEL_W-1:0] ch);
    int unsigned             pos;
    longint                  y1_full;
    longint                  y2_full;
    longint                  xd;
    longint                  num;
    logic signed [Y1_W-1:0]  y1;
    logic signed [Y2_W-1:0]  y2;
    if (int'(ch) >= NCH) return '0;
    pos = wr_ptr[ch];
    smp_mem[ch][pos] = x;
    y1_full = longint'(x) - longint'(smp_mem[ch][back(pos, LAG)])
              + longint'(y1_mem[ch][back(pos, 2)]);
    y1 = y1_full[Y1_W-1:0];
    y1_mem[ch][pos] = y1;
    y2_full = longint'(y1) - longint'(y1_mem[ch][back(pos, LAG)])
              + longint'(y2_prev[ch][1]);
    y2 = y2_full[Y2_W-1:0];
    y2_prev[ch][1] = y2_prev[ch][0];
    y2_prev[ch][0] = y2;
    xd = longint'(smp_mem[ch][back(pos, OUT_DLY)]);
    num = xd * GAIN - longint'(y2);
    wr_ptr[ch] = (pos + 1) % HIST_DEPTH;
    return FILT_W'(num / GAIN);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [FILT_W-1:0] got,
                                 input logic signed [FILT_W-1:0] want);
    $display("%0t MISMATCH %s: filtered got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_beat(input logic signed [SAMPLE_W-1:0] s,
                           input logic [CHANNEL_W-1:0] ch, input logic known,
                           input logic signed [FILT_W-1:0] typed);
    logic signed [FILT_W-1:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    channel  <= ch;
    do @(posedge clk); while (in_stall);
    pred = predict_filtered(s, ch);
    filt_exp_q.push_back(known ? typed : pred);
    beats_sent++;
  endtask

  // output side: check accepted beats, then pick next stall
  always @(posedge clk) begin : rx_side
    logic signed [FILT_W-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filt_exp_q.size() == 0) begin
          report_mismatch("beat with nothing expected", filtered, '0);
        end else begin
          want = filt_exp_q.pop_front();
          if (filtered !== want) report_mismatch("wrong value", filtered, want);
        end
      end
      out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin : pressure
    wait (beats_sent >= HOLD_AT);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin : watchdog
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main
    int                         phase;
    int                         done_n;
    int                         kind;
    int                         seg_len;
    int                         k;
    bit                         fixed_ch;
    logic [CHANNEL_W-1:0]       seg_ch;
    logic [CHANNEL_W-1:0]       ch;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W-1:0] step;
    logic signed [SAMPLE_W-1:0] val;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    sample    <= '0;
    channel   <= '0;
    for (int c = 0; c < CH_SLOTS; c++) begin
      wr_ptr[c]     = 0;
      y2_prev[c][0] = '0;
      y2_prev[c][1] = '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        smp_mem[c][i] = '0;
        y1_mem[c][i]  = '0;
      end
    end

    // zero input after reset gives zero out; other rows use the model
    dir_rows = '{
      '{24'h000000, 1'b0, 1'b1, 25'h0},
      '{24'h000000, 1'b1, 1'b1, 25'h0},
      '{24'h7FFFFF, 1'b0, 1'b0, 25'h0},
      '{24'h800000, 1'b0, 1'b0, 25'h0},
      '{24'h800000, 1'b1, 1'b0, 25'h0},
      '{24'h7FFFFF, 1'b1, 1'b0, 25'h0},
      '{24'hFFFFFF, 1'b0, 1'b0, 25'h0},
      '{24'h000001, 1'b1, 1'b0, 25'h0},
      '{24'h555555, 1'b0, 1'b0, 25'h0},
      '{24'hAAAAAA, 1'b0, 1'b0, 25'h0},
      '{24'h0F0F0F, 1'b1, 1'b0, 25'h0},
      '{24'hF0F0F0, 1'b1, 1'b0, 25'h0},
      '{24'h000640, 1'b0, 1'b0, 25'h0},
      '{24'hFFF9C0, 1'b0, 1'b0, 25'h0},
      '{24'h00063F, 1'b1, 1'b0, 25'h0},
      '{24'hFFF9C1, 1'b1, 1'b0, 25'h0},
      '{24'h7FFFFF, 1'b0, 1'b0, 25'h0},
      '{24'h7FFFFF, 1'b0, 1'b0, 25'h0},
      '{24'h800000, 1'b1, 1'b0, 25'h0},
      '{24'h800000, 1'b1, 1'b0, 25'h0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 9;
    recv_idle_pct <= 59;
    for (int i = 0; i < DIR_N; i++)
      send_beat(dir_rows[i].smp, dir_rows[i].ch, dir_rows[i].known, dir_rows[i].want);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 9;
          recv_idle_pct <= 59;
        end
        1: begin
          send_idle_pct  = 59;
          recv_idle_pct <= 9;
        end
        default: begin
          send_idle_pct  = 0;
          recv_idle_pct <= 0;
        end
      endcase
      done_n = 0;
      while (done_n < PHASE_BEATS) begin
        kind     = $urandom_range(4);
        seg_len  = $urandom_range(40, 5);
        fixed_ch = 1'($urandom_range(1));
        seg_ch   = CHANNEL_W'($urandom_range(1));
        base     = SAMPLE_W'($urandom);
        step     = SAMPLE_W'($urandom_range(2000)) - 24'sd1000;
        for (k = 0; k < seg_len && done_n < PHASE_BEATS; k++) begin
          case (kind)
            0:       val = SAMPLE_W'($urandom);
            1:       val = base;
            2:       val = k[0] ? 24'sh7FFFFF : 24'sh800000;
            3:       val = base + step * SAMPLE_W'(k);
            default: val = base + SAMPLE_W'($urandom_range(64)) - 24'sd32;
          endcase
          ch = fixed_ch ? seg_ch : CHANNEL_W'($urandom_range(1));
          send_beat(val, ch, 1'b0, '0);
          done_n++;
        end
      end
    end
    in_valid <= 1'b0;

    while (filt_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
